/* rtl/core/ptmu_pkg.sv */
// ============================================================================
// ptmu_pkg: shared types and constants for the price normalizer
// Request/response payloads, internal operation codes, status codes and
// configuration register indexes.
// ============================================================================
`default_nettype none

package ptmu_pkg;

    localparam int SCALE_W = 30;

    // Column form codes
    localparam logic [3:0] FORM_CENT32  = 4'd0;
    localparam logic [3:0] FORM_CENT64  = 4'd1;
    localparam logic [3:0] FORM_MILL32  = 4'd2;
    localparam logic [3:0] FORM_DOLLAR  = 4'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_CENT   = 2'd0;
    localparam logic [1:0] CFG_MILL   = 2'd1;
    localparam logic [1:0] CFG_DOLLAR = 2'd2;

    // Scale reset values
    localparam logic [SCALE_W-1:0] CENT_RST   = 30'd10000;
    localparam logic [SCALE_W-1:0] MILL_RST   = 30'd1000;
    localparam logic [SCALE_W-1:0] DOLLAR_RST = 30'd1000000;

    // binary64 exponent bias plus fraction width
    localparam logic signed [11:0] EXP_LSB_BIAS = 12'sd1075;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FORM  = 2'd3;

    // Operation decided by the front end
    typedef enum logic [2:0] {
        OP_CENT,
        OP_MILL,
        OP_DBL,
        OP_ZERO,
        OP_NONFIN,
        OP_NOTPRICE
    } t_op;

    typedef struct packed {
        logic [3:0]         column_form;
        logic signed [63:0] integer_value;
        logic [63:0]        real_bits;
    } t_req;

    typedef struct packed {
        logic signed [63:0] micro_units;
        logic [1:0]         status;
    } t_rsp;

    // Classified request as held in the queue
    typedef struct packed {
        t_op         op;
        logic [63:0] operand;
    } t_item;

    typedef struct packed {
        logic [SCALE_W-1:0] cent;
        logic [SCALE_W-1:0] mill;
        logic [SCALE_W-1:0] dollar;
    } t_scales;

endpackage

`default_nettype wire

/* rtl/core/ptmu_stream_if.sv */
// ============================================================================
// ptmu_stream_if: valid/ready channel
// Carries one item of type T per handshake.
// ============================================================================
`default_nettype none

interface ptmu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/price_to_micro_units_unit.sv */
// ============================================================================
// price_to_micro_units_unit: price normalizer to signed micro-dollar units
// Cent/mill integers scaled with overflow check; binary64 dollars scaled in
// double precision and rounded to integer, ties to even.
// ============================================================================
// Path: the queue, then 6 pipeline stages, from request to response.
// Throughput: one request per cycle; the whole back pipeline holds on a
// stalled response, the queue absorbs one extra request meanwhile.
// Reset: synchronous active low; clears queue and stage valids, loads scale
// registers with 10000, 1000 and 1000000.
`default_nettype none

module price_to_micro_units_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    ptmu_stream_if.sink                    i_req,
    ptmu_stream_if.source                  o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [ptmu_pkg::SCALE_W-1:0] i_cfg_wdata
);
    import ptmu_pkg::*;

    t_scales r_scales;

    // Scale registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scales.cent   <= CENT_RST;
            r_scales.mill   <= MILL_RST;
            r_scales.dollar <= DOLLAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENT:   r_scales.cent   <= i_cfg_wdata;
                CFG_MILL:   r_scales.mill   <= i_cfg_wdata;
                CFG_DOLLAR: r_scales.dollar <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    ptmu_stream_if #(.T(t_item)) u_q_in  ();
    ptmu_stream_if #(.T(t_item)) u_q_out ();

    ptmu_front u_front (
        .i_req  (i_req),
        .o_item (u_q_in)
    );

    ptmu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (u_q_in),
        .o_rd    (u_q_out)
    );

    ptmu_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scales (r_scales),
        .i_item   (u_q_out),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/ptmu_front.sv */
// ============================================================================
// ptmu_front: request classifier
// Decodes the column form and the double class, picks the operand.
// ============================================================================
`default_nettype none

module ptmu_front (
    ptmu_stream_if.sink   i_req,
    ptmu_stream_if.source o_item
);
    import ptmu_pkg::*;

    logic [10:0] exp_f;

    assign exp_f        = i_req.data.real_bits[62:52];
    assign o_item.valid = i_req.valid;
    assign i_req.ready  = o_item.ready;

    // Classify the request
    always_comb begin
        o_item.data.operand = i_req.data.integer_value;
        unique case (i_req.data.column_form) inside
            FORM_CENT32, FORM_CENT64: begin
                o_item.data.op = OP_CENT;
            end
            FORM_MILL32: begin
                o_item.data.op = OP_MILL;
            end
            FORM_DOLLAR: begin
                o_item.data.operand = i_req.data.real_bits;
                if (exp_f == 11'h7FF) begin
                    o_item.data.op = OP_NONFIN;
                end else if (exp_f == 11'h000) begin
                    // zero or subnormal: product rounds to zero
                    o_item.data.op = OP_ZERO;
                end else begin
                    o_item.data.op = OP_DBL;
                end
            end
            default: begin
                o_item.data.op = OP_NOTPRICE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/ptmu_queue.sv */
// ============================================================================
// ptmu_queue: small request queue
// Decouples the classifier from the arithmetic pipeline.
// ============================================================================
`default_nettype none

module ptmu_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ptmu_stream_if.sink   i_wr,
    ptmu_stream_if.source o_rd
);
    import ptmu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign i_wr.ready = (r_cnt != CNT_W'(DEPTH));
    assign o_rd.valid = (r_cnt != '0);
    assign o_rd.data  = r_mem[r_rd];
    assign push       = i_wr.valid && i_wr.ready;
    assign pop        = o_rd.valid && o_rd.ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not rise on push");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not fall on pop");

endmodule

`default_nettype wire

/* rtl/core/ptmu_back.sv */
// ============================================================================
// ptmu_back: scaling pipeline
// Six stages: partial products, product sum, normalize shift, round to
// double, integer alignment, integer round and result select.
// ============================================================================
`default_nettype none

module ptmu_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ptmu_pkg::t_scales i_scales,
    ptmu_stream_if.sink           i_item,
    ptmu_stream_if.source         o_rsp
);
    import ptmu_pkg::*;

    logic en;

    // Stage A
    logic               rA_v;
    t_op                rA_op;
    logic               rA_sign;
    logic [10:0]        rA_e;
    logic [61:0]        rA_plo;
    logic [62:0]        rA_phi;
    logic [4:0]         rA_ls;
    logic               rA_sz;
    // Stage B
    logic               rB_v;
    t_op                rB_op;
    logic               rB_sign;
    logic [10:0]        rB_e;
    logic [94:0]        rB_p;
    logic [4:0]         rB_ls;
    logic               rB_sz;
    // Stage C
    logic               rC_v;
    t_op                rC_op;
    logic               rC_sign;
    logic [52:0]        rC_q;
    logic               rC_g;
    logic               rC_st;
    logic signed [11:0] rC_f;
    logic [63:0]        rC_int;
    logic               rC_ovf;
    // Stage D
    logic               rD_v;
    t_op                rD_op;
    logic               rD_sign;
    logic [52:0]        rD_q;
    logic signed [11:0] rD_f;
    logic [63:0]        rD_int;
    logic               rD_ovf;
    // Stage E
    logic               rE_v;
    t_op                rE_op;
    logic               rE_sign;
    logic [63:0]        rE_mag;
    logic               rE_g;
    logic               rE_st;
    logic               rE_refuse;
    logic [63:0]        rE_int;
    logic               rE_ovf;
    // Output register
    logic               r_out_v;
    t_rsp               r_out;

    assign en           = !r_out_v || o_rsp.ready;
    assign i_item.ready = en;
    assign o_rsp.valid  = r_out_v;
    assign o_rsp.data   = r_out;

    // Stage A: scale select, shared partial products
    logic [SCALE_W-1:0] sel_s;
    logic [31:0]        a_lo;
    logic [32:0]        a_hi;
    logic [61:0]        plo;
    logic signed [63:0] ahi_x;
    logic signed [63:0] s_x;
    logic signed [63:0] phi_w;
    logic [4:0]         ls;

    always_comb begin
        case (i_item.data.op)
            OP_CENT: sel_s = i_scales.cent;
            OP_MILL: sel_s = i_scales.mill;
            default: sel_s = i_scales.dollar;
        endcase
        a_lo = i_item.data.operand[31:0];
        if (i_item.data.op == OP_DBL) begin
            a_hi = {12'b0, 1'b1, i_item.data.operand[51:32]};
        end else begin
            a_hi = {i_item.data.operand[63], i_item.data.operand[63:32]};
        end
        ahi_x = {{31{a_hi[32]}}, a_hi};
        s_x   = {34'b0, sel_s};
        plo   = 62'(a_lo) * 62'(sel_s);
        phi_w = ahi_x * s_x;
        // leading one of the scale
        ls = '0;
        for (int i = 0; i < SCALE_W; i++) begin
            if (sel_s[i]) ls = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rA_op   <= i_item.data.op;
            rA_sign <= i_item.data.operand[63];
            rA_e    <= i_item.data.operand[62:52];
            rA_plo  <= plo;
            rA_phi  <= phi_w[62:0];
            rA_ls   <= ls;
            rA_sz   <= (sel_s == '0);
        end
    end

    // Stage B: full product
    logic signed [94:0] sum_b;
    assign sum_b = $signed({rA_phi, 32'b0}) + $signed({33'b0, rA_plo});

    always_ff @(posedge i_clk) begin
        if (en) begin
            rB_op   <= rA_op;
            rB_sign <= rA_sign;
            rB_e    <= rA_e;
            rB_p    <= sum_b;
            rB_ls   <= rA_ls;
            rB_sz   <= rA_sz;
        end
    end

    // Stage C: overflow check; align mantissa product to 53 bits
    logic [82:0]        p_c;
    logic [6:0]         top_idx;
    logic [4:0]         k_c;
    logic [82:0]        shf_c;
    logic [82:0]        one_k;
    logic               g_c;
    logic               st_c;
    logic signed [11:0] f_c;
    t_op                op_c;

    always_comb begin
        p_c     = rB_p[82:0];
        top_idx = 7'd53 + {2'b0, rB_ls};
        k_c     = p_c[top_idx] ? rB_ls + 5'd1 : rB_ls;
        shf_c   = p_c >> k_c;
        one_k   = 83'd1 << k_c;
        g_c     = |(p_c & (one_k >> 1));
        st_c    = |(p_c & ((one_k - 83'd1) >> 1));
        f_c     = $signed({1'b0, rB_e}) - EXP_LSB_BIAS + $signed({7'b0, k_c});
        op_c    = (rB_op == OP_DBL && rB_sz) ? OP_ZERO : rB_op;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rC_op   <= op_c;
            rC_sign <= rB_sign;
            rC_q    <= shf_c[52:0];
            rC_g    <= g_c;
            rC_st   <= st_c;
            rC_f    <= f_c;
            rC_int  <= rB_p[63:0];
            rC_ovf  <= !((rB_p[94:63] == '0) || (rB_p[94:63] == '1));
        end
    end

    // Stage D: round to double precision, renormalize on carry
    logic [53:0] qr_d;
    assign qr_d = {1'b0, rC_q} + 54'(rC_g && (rC_st || rC_q[0]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            rD_op   <= rC_op;
            rD_sign <= rC_sign;
            rD_q    <= qr_d[53] ? qr_d[53:1] : qr_d[52:0];
            rD_f    <= qr_d[53] ? rC_f + 12'sd1 : rC_f;
            rD_int  <= rC_int;
            rD_ovf  <= rC_ovf;
        end
    end

    // Stage E: align to integer, range check
    logic [63:0] mag_e;
    logic        g_e;
    logic        st_e;
    logic        ref_e;
    logic [11:0] n_e;
    logic [5:0]  nn_e;
    logic [53:0] m54;
    logic [53:0] q54;

    always_comb begin
        mag_e = '0;
        g_e   = 1'b0;
        st_e  = 1'b0;
        ref_e = 1'b0;
        n_e   = 12'(-rD_f);
        nn_e  = n_e[5:0];
        q54   = {1'b0, rD_q};
        m54   = 54'd1 << nn_e;
        if (!rD_f[11]) begin
            // exactly -2^63 is the one value at exponent 11 that fits
            ref_e = (rD_f > 12'sd11) ||
                    (rD_f == 12'sd11 && !(rD_sign && rD_q == (53'd1 << 52)));
            mag_e = 64'(rD_q) << rD_f[3:0];
        end else if (n_e <= 12'd54) begin
            mag_e = 64'(rD_q >> nn_e);
            g_e   = |(q54 & (m54 >> 1));
            st_e  = |(q54 & ((m54 - 54'd1) >> 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rE_op     <= rD_op;
            rE_sign   <= rD_sign;
            rE_mag    <= mag_e;
            rE_g      <= g_e;
            rE_st     <= st_e;
            rE_refuse <= ref_e;
            rE_int    <= rD_int;
            rE_ovf    <= rD_ovf;
        end
    end

    // Stage F: integer round, sign, result select
    logic [63:0] rnd_f;
    logic [63:0] val_f;
    t_rsp        rsp_f;

    always_comb begin
        rnd_f = rE_mag + 64'(rE_g && (rE_st || rE_mag[0]));
        val_f = rE_sign ? -rnd_f : rnd_f;
        rsp_f.micro_units = '0;
        rsp_f.status      = ST_OK;
        case (rE_op)
            OP_CENT, OP_MILL: begin
                if (rE_ovf) rsp_f.status = ST_OVF;
                else        rsp_f.micro_units = rE_int;
            end
            OP_DBL: begin
                if (rE_refuse) rsp_f.status = ST_RANGE;
                else           rsp_f.micro_units = val_f;
            end
            OP_ZERO:   rsp_f.status = ST_OK;
            OP_NONFIN: rsp_f.status = ST_RANGE;
            default:   rsp_f.status = ST_FORM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= rsp_f;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_v    <= 1'b0;
            rB_v    <= 1'b0;
            rC_v    <= 1'b0;
            rD_v    <= 1'b0;
            rE_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            rA_v    <= i_item.valid;
            rB_v    <= rA_v;
            rC_v    <= rB_v;
            rD_v    <= rC_v;
            rE_v    <= rD_v;
            r_out_v <= rE_v;
        end
    end

endmodule

`default_nettype wire

/* bench/tb_price_to_micro_units_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_price_to_micro_units_unit: self-checking bench for the price normalizer
// A short directed table is run first: extremes, every column form, refused
// values and half-way ties. Scale writes sit in the table between requests.
// Random phases follow, each with new scales drawn from zero, one, the top
// of the range and random values; their responses are checked against a
// behavioral model in native double arithmetic, directed ones by the table.
// ============================================================================
module tb_price_to_micro_units_unit;
    import ptmu_pkg::*;

    localparam int LAT      = 7;
    localparam int N_PHASES = 10;
    localparam int N_PER_PH = 110;

    typedef struct {
        bit                 is_cfg;
        logic [1:0]         idx;
        logic [SCALE_W-1:0] wdata;
        t_req               req;
        bit                 typed;
        t_rsp               rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [SCALE_W-1:0] i_cfg_wdata;

    ptmu_stream_if #(.T(t_req)) req_if ();
    ptmu_stream_if #(.T(t_rsp)) rsp_if ();

    price_to_micro_units_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_scales cur_scales;
    t_rsp    pending_prices[$];
    t_row    dir_rows[$];
    int      mismatches;
    bit      idle_en;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Expected response for one request, from the current scales
    function automatic t_rsp scale_price(t_req r);
        t_rsp               o;
        logic [SCALE_W-1:0] s;
        logic signed [127:0] a, b, prod;
        real                p;
        logic [63:0]        pb, mant, mag, q, rem, half;
        logic [10:0]        ex;
        int                 e, sh;
        o = '0;
        case (r.column_form)
            FORM_CENT32, FORM_CENT64, FORM_MILL32: begin
                s = (r.column_form == FORM_MILL32) ? cur_scales.mill : cur_scales.cent;
                a = r.integer_value;
                b = {98'd0, s};
                prod = a * b;
                if (prod != {{64{prod[63]}}, prod[63:0]})
                    o.status = ST_OVF;
                else
                    o.micro_units = prod[63:0];
            end
            FORM_DOLLAR: begin
                if (r.real_bits[62:52] == 11'h7FF) begin
                    o.status = ST_RANGE;
                end else begin
                    p = $bitstoreal(r.real_bits) * real'(cur_scales.dollar);
                    pb = $realtobits(p);
                    if (pb[62:52] == 11'h7FF || !(p >= -9223372036854775808.0) ||
                        !(p < 9223372036854775808.0)) begin
                        o.status = ST_RANGE;
                    end else begin
                        // integer part by hand, ties to even
                        ex = pb[62:52];
                        mant = {11'd0, (ex != 0), pb[51:0]};
                        e = ((ex == 0) ? 1 : int'(ex)) - 1075;
                        if (e >= 0) begin
                            mag = mant << e;
                        end else begin
                            sh = -e;
                            if (sh > 63) begin
                                mag = '0;
                            end else begin
                                q = mant >> sh;
                                rem = mant & ((64'd1 << sh) - 64'd1);
                                half = 64'd1 << (sh - 1);
                                mag = q + ((rem > half || (rem == half && q[0])) ? 1 : 0);
                            end
                        end
                        o.micro_units = pb[63] ? -mag : mag;
                    end
                end
            end
            default: o.status = ST_FORM;
        endcase
        return o;
    endfunction

    function automatic t_row req_row(logic [3:0] f, logic [63:0] iv, logic [63:0] rb,
                                     bit typed, logic [63:0] mu, logic [1:0] st);
        t_row w;
        w = '{default: '0};
        w.req = '{column_form: f, integer_value: iv, real_bits: rb};
        w.typed = typed;
        w.rsp = '{micro_units: mu, status: st};
        return w;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, logic [SCALE_W-1:0] d);
        t_row w;
        w = '{default: '0};
        w.is_cfg = 1'b1;
        w.idx = idx;
        w.wdata = d;
        return w;
    endfunction

    // Drive one request; called and returns at a falling edge
    task automatic send_price(t_req r, bit typed, t_rsp given);
        while (idle_en && $urandom_range(99) < 23) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data = r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_prices.push_back(typed ? given : scale_price(r));
        @(negedge i_clk);
    endtask

    // Scale write once the pipe has drained
    task automatic write_scale(logic [1:0] idx, logic [SCALE_W-1:0] d);
        req_if.valid = 1'b0;
        while (pending_prices.size() != 0) @(negedge i_clk);
        repeat (LAT + 3) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CENT:   cur_scales.cent = d;
            CFG_MILL:   cur_scales.mill = d;
            CFG_DOLLAR: cur_scales.dollar = d;
            default: ;
        endcase
    endtask

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(5))
            0: return '0;
            1: return 30'd1;
            2: return 30'd1000000000;
            3: return '1;
            4: return 30'd1 << $urandom_range(29);
            default: return 30'($urandom_range(1, 1000000000));
        endcase
    endfunction

    function automatic logic [63:0] pick_integer(logic [SCALE_W-1:0] s);
        logic [63:0] lim;
        case ($urandom_range(4))
            0: return 64'($signed($urandom_range(2097152)) - 1048576);
            1: return {$urandom, $urandom};
            2: begin
                lim = (s == 0) ? 64'd1 : (64'h7FFF_FFFF_FFFF_FFFF / s);
                lim = lim + $urandom_range(2) - 1;
                return $urandom_range(1) ? lim : -lim - $urandom_range(1);
            end
            3: return $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
            default: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_double();
        logic [63:0] pb;
        real         k;
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: return {$urandom_range(1) ? 1'b1 : 1'b0, 11'h7FF,
                       20'($urandom), $urandom};
            2: return {$urandom_range(1) ? 1'b1 : 1'b0, 11'h000,
                       20'($urandom), $urandom};
            3: begin
                k = real'($signed($urandom_range(2097152)) - 1048576);
                return $realtobits(k + 0.5);
            end
            4: begin
                // just around the top of the signed range
                pb = $realtobits(9223372036854775808.0 /
                                 real'((cur_scales.dollar == 0) ? 1 : cur_scales.dollar));
                pb = pb + $urandom_range(4) - 2;
                pb[63] = 1'($urandom_range(1));
                return pb;
            end
            default: return {$urandom_range(1) ? 1'b1 : 1'b0,
                             11'(993 + $urandom_range(95)), 20'($urandom), $urandom};
        endcase
    endfunction

    // Random ready on the response side
    always @(negedge i_clk)
        rsp_if.ready = !(idle_en && $urandom_range(99) < 23);

    // Response check
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_prices.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response with none expected: mu=%0d st=%0d",
                             rsp_if.data.micro_units, rsp_if.data.status);
            end else begin
                want = pending_prices.pop_front();
                if (rsp_if.data.micro_units !== want.micro_units ||
                    rsp_if.data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp mu=%0d st=%0d got mu=%0d st=%0d",
                                 want.micro_units, want.status,
                                 rsp_if.data.micro_units, rsp_if.data.status);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus
    initial begin
        t_req r;
        t_rsp none;
        logic [3:0] f;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b1;
        idle_en = 1'b1;
        mismatches = 0;
        cur_scales = '{cent: CENT_RST, mill: MILL_RST, dollar: DOLLAR_RST};

        // directed table, reset scales first
        dir_rows.push_back(req_row(FORM_CENT32, 64'd1, '0, 1, 64'd10000, ST_OK));
        dir_rows.push_back(req_row(FORM_CENT32, 64'd0, '1, 1, 64'd0, ST_OK));
        dir_rows.push_back(req_row(FORM_CENT32, -64'sd1, '0, 1, -64'sd10000, ST_OK));
        dir_rows.push_back(req_row(FORM_CENT64, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1, 0, ST_OVF));
        dir_rows.push_back(req_row(FORM_CENT64, 64'h8000_0000_0000_0000, '0, 1, 0, ST_OVF));
        dir_rows.push_back(req_row(FORM_MILL32, 64'd5, '0, 1, 64'd5000, ST_OK));
        dir_rows.push_back(req_row(FORM_MILL32, -64'sd7, '1, 1, -64'sd7000, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '1, 64'h3FF0_0000_0000_0000, 1,
                                   64'd1000000, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h8000_0000_0000_0000, 1, 0, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h0000_0000_0000_0001, 1, 0, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h7FF0_0000_0000_0000, 1, 0, ST_RANGE));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h7FF8_0000_0000_0001, 1, 0, ST_RANGE));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'hFFF0_0000_0000_0000, 1, 0, ST_RANGE));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h7E37_E43C_8800_759C, 1, 0, ST_RANGE));
        dir_rows.push_back(req_row(4'd4, 64'd1, 64'h3FF0_0000_0000_0000, 1, 0, ST_FORM));
        dir_rows.push_back(req_row(4'd15, '1, '1, 1, 0, ST_FORM));
        // unit dollar scale: ties and the edges of the signed range
        dir_rows.push_back(cfg_row(CFG_DOLLAR, 30'd1));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h4004_0000_0000_0000, 1, 64'd2, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h400C_0000_0000_0000, 1, 64'd4, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'hC004_0000_0000_0000, 1,
                                   -64'sd2, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h3FE0_0000_0000_0000, 1, 0, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'hC3E0_0000_0000_0000, 1,
                                   64'h8000_0000_0000_0000, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h43E0_0000_0000_0000, 1, 0, ST_RANGE));
        // zero and full-width scales
        dir_rows.push_back(cfg_row(CFG_CENT, 30'd0));
        dir_rows.push_back(req_row(FORM_CENT64, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1, 0, ST_OK));
        dir_rows.push_back(cfg_row(CFG_MILL, '1));
        dir_rows.push_back(req_row(FORM_MILL32, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1, 0, ST_OVF));
        dir_rows.push_back(cfg_row(CFG_DOLLAR, 30'd0));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'h3FF0_0000_0000_0000, 1, 0, ST_OK));
        dir_rows.push_back(req_row(FORM_DOLLAR, '0, 64'hFFF0_0000_0000_0000, 1, 0, ST_RANGE));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_cfg)
                write_scale(dir_rows[n].idx, dir_rows[n].wdata);
            else
                send_price(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp);
        end

        // random phases; one of them runs with no idling at all
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_scale(CFG_CENT, pick_scale());
            write_scale(CFG_MILL, pick_scale());
            write_scale(CFG_DOLLAR, pick_scale());
            idle_en = (ph != 4);
            for (int k = 0; k < N_PER_PH; k++) begin
                f = ($urandom_range(99) < 85) ? 4'($urandom_range(3))
                                              : 4'($urandom_range(4, 15));
                r.column_form = f;
                r.integer_value = pick_integer((f == FORM_MILL32) ? cur_scales.mill
                                                                  : cur_scales.cent);
                r.real_bits = pick_double();
                send_price(r, 0, none);
            end
        end
        req_if.valid = 1'b0;
        idle_en = 1'b1;

        while (pending_prices.size() != 0) @(negedge i_clk);
        repeat (LAT * 3) @(negedge i_clk);
        if (mismatches == 0 && pending_prices.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ptmu_pkg.sv
rtl/core/ptmu_stream_if.sv
rtl/core/ptmu_front.sv
rtl/core/ptmu_queue.sv
rtl/core/ptmu_back.sv
rtl/core/price_to_micro_units_unit.sv
bench/tb_price_to_micro_units_unit.sv
